### sv/fbpa_pkg.sv
// Shared types and constants for the fixed-size block pool allocator.
// Used by the channel interfaces, the serial arithmetic units and the top level.
`default_nettype none

package fbpa_pkg;

    // Field widths of the request and response transactions
    localparam int OP_W     = 2;
    localparam int BYTES_W  = 16;
    localparam int OFF_W    = 24;
    localparam int STS_W    = 3;
    localparam int CNT_W    = 9;
    localparam int FAIL_W   = 32;

    // Configuration register widths
    localparam int SIZE_W    = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_ALIGNMENT = 2'd2;

    // Configuration reset values
    localparam logic [SIZE_W-1:0] RST_BLOCK_BYTES    = 13'd64;
    localparam logic [CNT_W-1:0]  RST_BLOCKS_IN_USE  = 9'd256;
    localparam logic [SIZE_W-1:0] RST_POOL_ALIGNMENT = 13'd8;

    // Saturation limits of the counters
    localparam logic [CNT_W-1:0]  USED_MAX = '1;
    localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

    // Request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_RESET = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Response status codes
    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_TOO_LARGE = 3'd1,
        STS_ALIGN     = 3'd2,
        STS_EMPTY     = 3'd3,
        STS_NOT_OWNED = 3'd4,
        STS_NULL      = 3'd5
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LINK,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

### sv/fbpa_req_if.sv
// Request channel of the block pool allocator: valid/ready plus request fields.
// Depends on fbpa_pkg for the field widths.
`default_nettype none

interface fbpa_req_if;
    import fbpa_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [BYTES_W-1:0] request_bytes;
    logic [BYTES_W-1:0] request_align;
    logic [OFF_W-1:0]   release_offset;
    logic               release_is_null;

    modport source (
        output valid, operation, request_bytes, request_align,
               release_offset, release_is_null,
        input  ready
    );

    modport sink (
        input  valid, operation, request_bytes, request_align,
               release_offset, release_is_null,
        output ready
    );

endinterface

`default_nettype wire

### sv/fbpa_rsp_if.sv
// Response channel of the block pool allocator: valid/ready plus result fields.
// Depends on fbpa_pkg for the field widths.
`default_nettype none

interface fbpa_rsp_if;
    import fbpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic [OFF_W-1:0]  block_offset;
    logic [CNT_W-1:0]  used_blocks;
    logic [FAIL_W-1:0] failed_allocations;

    modport source (
        output valid, status, block_offset, used_blocks, failed_allocations,
        input  ready
    );

    modport sink (
        input  valid, status, block_offset, used_blocks, failed_allocations,
        output ready
    );

endinterface

`default_nettype wire

### sv/fbpa_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Splits a byte offset into block index and remainder; depends on fbpa_pkg.
`default_nettype none

module fbpa_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [fbpa_pkg::OFF_W-1:0]  i_dividend,
    input  wire logic [fbpa_pkg::SIZE_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [fbpa_pkg::OFF_W-1:0]       o_quotient,
    output logic [fbpa_pkg::SIZE_W-1:0]      o_remainder
);
    import fbpa_pkg::*;

    localparam int STEP_W = $clog2(OFF_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [OFF_W-1:0]  r_quo;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_dvs;

    logic [SIZE_W:0]   rem_sh;
    logic [SIZE_W:0]   diff;
    logic              ge;

    // One restoring step: bring in the next dividend bit, trial subtract
    always_comb begin
        rem_sh = {r_rem, r_quo[OFF_W-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        diff   = rem_sh - {1'b0, r_dvs};
    end

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(OFF_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[OFF_W-2:0], ge};
            r_rem <= ge ? diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

### sv/fbpa_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
// Turns a block index into a byte offset modulo 2^24; depends on fbpa_pkg.
`default_nettype none

module fbpa_mul #(
    parameter int IDX_W = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [fbpa_pkg::SIZE_W-1:0] i_mcand,
    input  wire logic [IDX_W-1:0]            i_mplier,
    output logic                            o_done,
    output logic [fbpa_pkg::OFF_W-1:0]       o_product
);
    import fbpa_pkg::*;

    localparam int STEP_W = $clog2(IDX_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [OFF_W-1:0]  r_acc;
    logic [OFF_W-1:0]  r_mcand;
    logic [IDX_W-1:0]  r_mplier;

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(IDX_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Accumulate shifted multiplicand for each set multiplier bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= OFF_W'(i_mcand);
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[OFF_W-2:0], 1'b0};
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

`default_nettype wire

### sv/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator with a LIFO free list of block indices.
// Depends on fbpa_pkg, fbpa_req_if, fbpa_rsp_if, fbpa_div and fbpa_mul.
//
// Usage:
//   i_req carries allocate, free or pool-reset transactions; o_rsp returns
//   exactly one response transaction per request. The config port writes
//   block size, block count and pool alignment; the user must do so only
//   while the block is idle, which the block does not enforce. One request
//   is processed at a time; i_req.ready is high only when the sequencer is
//   idle and out of reset. Steps from acceptance to the response being
//   registered on o_rsp:
//     allocate from the fresh range   serial multiplier
//     allocate from the freed stack   link read, then serial multiplier
//     free of an owned/not-owned block 24-step serial divider
//     failures, null free, pool reset  neither unit
//   The divider sets the worst case, so a free holds the sequencer longest.
//   The response sits in an output register: the next request is accepted
//   while it waits, and a stalled receiver only holds the sequencer once the
//   following response is ready. Reset empties the freed stack and marks all
//   blocks fresh; the link memory needs no clearing pass.
`default_nettype none

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS      = 256,
    parameter int MAX_BLOCK_BYTES = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [fbpa_pkg::CFG_W-1:0]     i_cfg_data,
    fbpa_req_if.sink                           i_req,
    fbpa_rsp_if.source                         o_rsp
);
    import fbpa_pkg::*;

    localparam int IDX_W    = $clog2(MAX_BLOCKS);
    localparam int CNT_CAP  = (MAX_BLOCKS > 511) ? 511 : MAX_BLOCKS;
    localparam int SIZE_CAP = (MAX_BLOCK_BYTES > 8191) ? 8191 : MAX_BLOCK_BYTES;

    // Configuration registers
    logic [SIZE_W-1:0] r_block_bytes;
    logic [CNT_W-1:0]  r_blocks_in_use;
    logic [SIZE_W-1:0] r_pool_align;

    // Latched request
    t_op                r_op;
    logic [BYTES_W-1:0] r_req_bytes;
    logic [BYTES_W-1:0] r_req_align;
    logic [OFF_W-1:0]   r_rel_off;
    logic               r_rel_null;

    // Pool state
    t_state            r_state;
    t_state            n_state;
    logic              r_head_valid;
    logic [IDX_W-1:0]  r_free_head;
    logic [CNT_W-1:0]  r_fresh;
    logic [CNT_W-1:0]  r_used;
    logic [FAIL_W-1:0] r_fail;
    t_status           r_status;
    logic [OFF_W-1:0]  r_offset;

    // Link memory: {end-of-list flag, next index}
    logic [IDX_W:0]    r_link_mem [MAX_BLOCKS];
    logic [IDX_W:0]    r_link_rd;

    // Output register
    logic              r_out_valid;
    t_status           r_o_status;
    logic [OFF_W-1:0]  r_o_offset;
    logic [CNT_W-1:0]  r_o_used;
    logic [FAIL_W-1:0] r_o_fail;

    // Derived values and sequencer controls
    logic [SIZE_W-1:0] eff_size;
    logic [CNT_W-1:0]  eff_count;
    logic              too_large;
    logic              align_bad;
    logic              fresh_ok;
    logic              owned;
    logic              accept;
    logic              in_ready;
    logic              div_start;
    logic              mul_start;
    logic              mem_we;
    logic              out_load;
    logic [IDX_W-1:0]  mul_idx;

    logic              div_done;
    logic [OFF_W-1:0]  div_quo;
    logic [SIZE_W-1:0] div_rem;
    logic              mul_done;
    logic [OFF_W-1:0]  mul_prod;

    // Effective block size and count after clamping
    always_comb begin
        if (r_block_bytes == '0) begin
            eff_size = SIZE_W'(1);
        end else if (r_block_bytes > SIZE_W'(SIZE_CAP)) begin
            eff_size = SIZE_W'(SIZE_CAP);
        end else begin
            eff_size = r_block_bytes;
        end
        if (r_blocks_in_use > CNT_W'(CNT_CAP)) begin
            eff_count = CNT_W'(CNT_CAP);
        end else begin
            eff_count = r_blocks_in_use;
        end
    end

    // Request checks
    assign too_large = r_req_bytes > BYTES_W'(eff_size);
    assign align_bad = r_req_align > BYTES_W'(r_pool_align);
    assign fresh_ok  = r_fresh < eff_count;
    assign owned     = (div_rem == '0) && (div_quo < OFF_W'(eff_count));
    assign accept    = i_req.valid && in_ready;
    assign mul_idx   = (r_state == ST_LINK) ? r_free_head : IDX_W'(r_fresh);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes   <= RST_BLOCK_BYTES;
            r_blocks_in_use <= RST_BLOCKS_IN_USE;
            r_pool_align    <= RST_POOL_ALIGNMENT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLOCK_BYTES:    r_block_bytes   <= i_cfg_data;
                CFG_BLOCKS_IN_USE:  r_blocks_in_use <= i_cfg_data[CNT_W-1:0];
                CFG_POOL_ALIGNMENT: r_pool_align    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= t_op'(i_req.operation);
            r_req_bytes <= i_req.request_bytes;
            r_req_align <= i_req.request_align;
            r_rel_off   <= i_req.release_offset;
            r_rel_null  <= i_req.release_is_null;
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                unique case (r_op)
                    OP_ALLOC: begin
                        if (too_large || align_bad) n_state = ST_FIN;
                        else if (r_head_valid)      n_state = ST_LINK;
                        else if (fresh_ok)          n_state = ST_MUL;
                        else                        n_state = ST_FIN;
                    end
                    OP_FREE: n_state = r_rel_null ? ST_FIN : ST_DIV;
                    default: n_state = ST_FIN;
                endcase
            end
            ST_LINK: n_state = ST_MUL;
            ST_MUL: begin
                if (mul_done) n_state = ST_FIN;
            end
            ST_DIV: begin
                if (div_done) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || o_rsp.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        mul_start = 1'b0;
        mem_we    = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: in_ready = i_rst_n;
            ST_EVAL: begin
                div_start = (r_op == OP_FREE) && !r_rel_null;
                mul_start = (r_op == OP_ALLOC) && !too_large && !align_bad
                            && !r_head_valid && fresh_ok;
            end
            ST_LINK: mul_start = 1'b1;
            ST_DIV:  mem_we    = div_done && owned;
            ST_FIN:  out_load  = !r_out_valid || o_rsp.ready;
            default: ;
        endcase
    end

    // Free list, counters and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_free_head  <= '0;
            r_fresh      <= '0;
            r_used       <= '0;
            r_fail       <= '0;
            r_status     <= STS_OK;
            r_offset     <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_status <= STS_OK;
                        r_offset <= '0;
                    end
                end
                ST_EVAL: begin
                    case (r_op)
                        OP_ALLOC: begin
                            if (too_large) begin
                                r_status <= STS_TOO_LARGE;
                                if (r_fail != FAIL_MAX) r_fail <= r_fail + 1'b1;
                            end else if (align_bad) begin
                                r_status <= STS_ALIGN;
                                if (r_fail != FAIL_MAX) r_fail <= r_fail + 1'b1;
                            end else if (r_head_valid) begin
                                // popped in the link state
                            end else if (fresh_ok) begin
                                r_fresh <= r_fresh + 1'b1;
                                if (r_used != USED_MAX) r_used <= r_used + 1'b1;
                            end else begin
                                r_status <= STS_EMPTY;
                                if (r_fail != FAIL_MAX) r_fail <= r_fail + 1'b1;
                            end
                        end
                        OP_FREE: begin
                            if (r_rel_null) r_status <= STS_NULL;
                        end
                        OP_RESET: begin
                            r_head_valid <= 1'b0;
                            r_free_head  <= '0;
                            r_fresh      <= '0;
                            r_used       <= '0;
                        end
                        default: ;
                    endcase
                end
                ST_LINK: begin
                    // pop: follow the link of the head block
                    if (r_link_rd[IDX_W]) begin
                        r_head_valid <= 1'b0;
                        r_free_head  <= '0;
                    end else begin
                        r_free_head <= r_link_rd[IDX_W-1:0];
                    end
                    if (r_used != USED_MAX) r_used <= r_used + 1'b1;
                end
                ST_MUL: begin
                    if (mul_done) r_offset <= mul_prod;
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (owned) begin
                            r_free_head  <= div_quo[IDX_W-1:0];
                            r_head_valid <= 1'b1;
                            if (r_used != '0) r_used <= r_used - 1'b1;
                        end else begin
                            r_status <= STS_NOT_OWNED;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Link memory: push writes at the freed block, head link read every cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[div_quo[IDX_W-1:0]] <= {!r_head_valid,
                                               r_head_valid ? r_free_head : IDX_W'(0)};
        end
        r_link_rd <= r_link_mem[r_free_head];
    end

    // Response output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_status;
            r_o_offset <= r_offset;
            r_o_used   <= r_used;
            r_o_fail   <= r_fail;
        end
    end

    // Ownership check: offset / block size
    fbpa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_rel_off),
        .i_divisor   (eff_size),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Granted offset: block index * block size
    fbpa_mul #(
        .IDX_W (IDX_W)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (eff_size),
        .i_mplier  (mul_idx),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    assign i_req.ready              = in_ready;
    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.status             = r_o_status;
    assign o_rsp.block_offset       = r_o_offset;
    assign o_rsp.used_blocks        = r_o_used;
    assign o_rsp.failed_allocations = r_o_fail;

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the fixed-size block pool allocator.
// Needs fbpa_pkg, fbpa_req_if, fbpa_rsp_if and the allocator RTL; a built-in
// pool model predicts every response, including failures and counter saturation.
`timescale 1ns / 1ps

module testbench;
    import fbpa_pkg::*;

    localparam int unsigned POOL_MAX_BLOCKS = 256;
    localparam int unsigned POOL_MAX_BYTES  = 4096;
    localparam logic [CNT_W-1:0] LINK_END = 9'd256;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam int unsigned DRAIN_CYCLES = 30;
    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef struct {
        t_op                op;
        logic [BYTES_W-1:0] nbytes;
        logic [BYTES_W-1:0] align;
        logic [OFF_W-1:0]   off;
        logic               is_null;
    } t_pool_req;

    typedef struct {
        t_status           status;
        logic [OFF_W-1:0]  offset;
        logic [CNT_W-1:0]  used;
        logic [FAIL_W-1:0] fails;
    } t_pool_rsp;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    fbpa_req_if req_if ();
    fbpa_rsp_if rsp_if ();

    fixed_block_pool_allocator #(
        .MAX_BLOCKS      (POOL_MAX_BLOCKS),
        .MAX_BLOCK_BYTES (POOL_MAX_BYTES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // Pool model: configuration copy and free-list state
    logic [SIZE_W-1:0] cfg_block_bytes;
    logic [CNT_W-1:0]  cfg_block_cnt;
    logic [SIZE_W-1:0] cfg_align;
    logic [CNT_W-1:0]  link_mem [POOL_MAX_BLOCKS];
    logic [CNT_W-1:0]  stack_top;
    bit                stack_live;
    logic [CNT_W-1:0]  fresh_next;
    logic [CNT_W-1:0]  used_cnt;
    logic [FAIL_W-1:0] fail_cnt;

    t_pool_req queued_requests [$];
    t_pool_rsp due_responses [$];
    t_pool_req next_req;
    t_pool_req taken_req;
    t_pool_rsp due;
    bit req_fire;
    int unsigned idle_pct;
    int unsigned err_count;
    int unsigned cycle_cnt;

    function automatic int unsigned eff_block_size();
        if (cfg_block_bytes == 0) return 1;
        if (cfg_block_bytes > POOL_MAX_BYTES) return POOL_MAX_BYTES;
        return cfg_block_bytes;
    endfunction

    function automatic int unsigned eff_block_count();
        if (cfg_block_cnt > POOL_MAX_BLOCKS) return POOL_MAX_BLOCKS;
        return cfg_block_cnt;
    endfunction

    // Applies one transaction to the pool model and returns the response it owes
    function automatic t_pool_rsp predict_pool_response(t_pool_req rq);
        t_pool_rsp rs;
        int unsigned size;
        int unsigned count;
        int unsigned idx;
        bit got;
        size = eff_block_size();
        count = eff_block_count();
        rs.status = STS_OK;
        rs.offset = '0;
        got = 0;
        idx = 0;
        case (rq.op)
            OP_ALLOC: begin
                // size, then alignment, then exhaustion
                if (rq.nbytes > size) begin
                    rs.status = STS_TOO_LARGE;
                end else if (rq.align > cfg_align) begin
                    rs.status = STS_ALIGN;
                end else if (stack_live) begin
                    idx = stack_top;
                    if (link_mem[stack_top[7:0]] >= LINK_END) begin
                        stack_live = 0;
                        stack_top = '0;
                    end else begin
                        stack_top = link_mem[stack_top[7:0]];
                    end
                    got = 1;
                end else if (fresh_next < count) begin
                    idx = fresh_next;
                    fresh_next = fresh_next + 1'b1;
                    got = 1;
                end else begin
                    rs.status = STS_EMPTY;
                end
                if (got) begin
                    rs.offset = OFF_W'(idx * size);
                    if (used_cnt < USED_MAX) used_cnt = used_cnt + 1'b1;
                end else if (fail_cnt != FAIL_MAX) begin
                    fail_cnt = fail_cnt + 1'b1;
                end
            end
            OP_FREE: begin
                if (rq.is_null) begin
                    rs.status = STS_NULL;
                end else if (rq.off >= size * count || rq.off % size != 0) begin
                    rs.status = STS_NOT_OWNED;
                end else begin
                    // double frees are pushed as well
                    idx = (rq.off / size) % POOL_MAX_BLOCKS;
                    link_mem[idx] = stack_live ? stack_top : LINK_END;
                    stack_top = CNT_W'(idx);
                    stack_live = 1;
                    if (used_cnt > 0) used_cnt = used_cnt - 1'b1;
                end
            end
            OP_RESET: begin
                stack_live = 0;
                stack_top = '0;
                fresh_next = '0;
                used_cnt = '0;
            end
            default: ;
        endcase
        rs.used = used_cnt;
        rs.fails = fail_cnt;
        return rs;
    endfunction

    // Random transaction; mostly well-formed for the current configuration
    function automatic t_pool_req rand_req(int unsigned alloc_pct, bit with_reset);
        t_pool_req rq;
        int unsigned size;
        int unsigned count;
        int unsigned pick;
        size = eff_block_size();
        count = eff_block_count();
        rq.op = t_op'(OP_W'($urandom_range(3)));
        rq.nbytes = BYTES_W'($urandom);
        rq.align = BYTES_W'($urandom);
        rq.off = OFF_W'($urandom);
        rq.is_null = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < alloc_pct) begin
            rq.op = OP_ALLOC;
            rq.nbytes = BYTES_W'($urandom_range(size));
            rq.align = BYTES_W'($urandom_range(cfg_align));
        end else begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                rq.op = OP_FREE;
                rq.is_null = 0;
                rq.off = OFF_W'(((count == 0) ? 0 : $urandom_range(count - 1)) * size);
            end else if (pick < 65) begin
                rq.op = OP_FREE;
                rq.is_null = 1;
            end else if (pick < 75) begin
                // near the pool end or just off a block boundary
                rq.op = OP_FREE;
                rq.is_null = 0;
                rq.off = OFF_W'($urandom_range(count) * size + $urandom_range(2));
            end else if (pick < 80 && with_reset) begin
                rq.op = OP_RESET;
            end else if (pick < 85) begin
                rq.op = OP_NONE;
            end else begin
                rq.op = OP_ALLOC;
            end
        end
        return rq;
    endfunction

    task automatic add_req(t_op op, int unsigned nbytes, int unsigned align,
                           int unsigned off, bit is_null);
        t_pool_req rq;
        rq.op = op;
        rq.nbytes = BYTES_W'(nbytes);
        rq.align = BYTES_W'(align);
        rq.off = OFF_W'(off);
        rq.is_null = is_null;
        queued_requests.push_back(rq);
    endtask

    task automatic add_random(int unsigned n, int unsigned alloc_pct, bit with_reset);
        repeat (n) queued_requests.push_back(rand_req(alloc_pct, with_reset));
    endtask

    task automatic flag_error(string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR cycle %0d: %s", cycle_cnt, msg);
    endtask

    // Pool is quiet once nothing is queued, offered or outstanding; checked on
    // the rising edge, where the driver's queue and valid are settled
    task automatic wait_idle();
        do @(posedge i_clk);
        while (queued_requests.size() != 0 || req_if.valid || due_responses.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_W'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_pool(int unsigned bytes, int unsigned cnt, int unsigned align);
        wait_idle();
        write_reg(CFG_BLOCK_BYTES, bytes);
        write_reg(CFG_BLOCKS_IN_USE, cnt);
        write_reg(CFG_POOL_ALIGNMENT, align);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Cycle count and timeout
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Request side: model reset, register copies, prediction on each transaction
    always @(posedge i_clk) begin
        req_fire <= req_if.valid && req_if.ready;
        if (!i_rst_n) begin
            cfg_block_bytes <= RST_BLOCK_BYTES;
            cfg_block_cnt <= RST_BLOCKS_IN_USE;
            cfg_align <= RST_POOL_ALIGNMENT;
            stack_live = 0;
            stack_top = '0;
            fresh_next = '0;
            used_cnt = '0;
            fail_cnt = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLOCK_BYTES:    cfg_block_bytes <= i_cfg_data[SIZE_W-1:0];
                    CFG_BLOCKS_IN_USE:  cfg_block_cnt <= i_cfg_data[CNT_W-1:0];
                    CFG_POOL_ALIGNMENT: cfg_align <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (req_if.valid && req_if.ready) begin
                taken_req.op = t_op'(req_if.operation);
                taken_req.nbytes = req_if.request_bytes;
                taken_req.align = req_if.request_align;
                taken_req.off = req_if.release_offset;
                taken_req.is_null = req_if.release_is_null;
                due_responses.push_back(predict_pool_response(taken_req));
            end
        end
    end

    // Driver: next request and response backpressure, both on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && (!req_if.valid || req_fire)) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_req = queued_requests.pop_front();
                req_if.valid <= 1'b1;
                req_if.operation <= next_req.op;
                req_if.request_bytes <= next_req.nbytes;
                req_if.request_align <= next_req.align;
                req_if.release_offset <= next_req.off;
                req_if.release_is_null <= next_req.is_null;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
        rsp_if.ready <= i_rst_n && ($urandom_range(99) >= idle_pct);
    end

    // Response monitor: each transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (due_responses.size() == 0) begin
                flag_error("response with no request outstanding");
            end else begin
                due = due_responses.pop_front();
                if (rsp_if.status !== due.status || rsp_if.block_offset !== due.offset ||
                    rsp_if.used_blocks !== due.used ||
                    rsp_if.failed_allocations !== due.fails) begin
                    flag_error($sformatf({"status exp %0d got %0d, offset exp %h got %h, ",
                        "used exp %0d got %0d, fails exp %0d got %0d"},
                        due.status, rsp_if.status, due.offset, rsp_if.block_offset,
                        due.used, rsp_if.used_blocks, due.fails,
                        rsp_if.failed_allocations));
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.operation = OP_NONE;
        req_if.request_bytes = '0;
        req_if.request_align = '0;
        req_if.release_offset = '0;
        req_if.release_is_null = 1'b0;
        rsp_if.ready = 1'b0;
        req_fire = 0;
        idle_pct = 12;
        err_count = 0;
        cycle_cnt = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset configuration, 64-byte blocks, 256 of them, 8-byte alignment
        add_req(OP_ALLOC, 0, 0, 0, 0);
        add_req(OP_ALLOC, 64, 8, 0, 0);
        add_req(OP_ALLOC, 65, 0, 0, 0);
        add_req(OP_ALLOC, 65535, 65535, 0, 0);       // too large wins over alignment
        add_req(OP_ALLOC, 1, 9, 0, 0);
        add_req(OP_ALLOC, 0, 65535, 0, 0);
        add_req(OP_FREE, 0, 0, 24'hFFFFFF, 1);       // null checked before ownership
        add_req(OP_FREE, 0, 0, 24'hFFFFFF, 0);
        add_req(OP_FREE, 0, 0, 65, 0);
        add_req(OP_FREE, 0, 0, 64 * 256, 0);
        add_req(OP_FREE, 65535, 65535, 64, 0);
        add_req(OP_FREE, 0, 0, 0, 0);
        add_req(OP_FREE, 0, 0, 0, 0);                // double free, used stays at zero
        add_req(OP_ALLOC, 8, 8, 0, 0);
        add_req(OP_ALLOC, 8, 8, 0, 0);
        add_req(OP_NONE, 65535, 65535, 24'hFFFFFF, 1);
        add_req(OP_RESET, 0, 0, 0, 0);               // failures survive a pool reset
        add_req(OP_ALLOC, 16, 8, 0, 0);
        add_req(OP_ALLOC, 64, 0, 0, 0);
        add_req(OP_FREE, 0, 0, 255 * 64, 0);         // never handed out, still owned
        add_req(OP_ALLOC, 1, 1, 0, 0);
        add_req(OP_ALLOC, 1, 1, 0, 0);

        // Tiny pool of one-byte blocks, runs empty quickly
        set_pool(1, 4, 1);
        add_random(120, 40, 1);

        // Largest blocks, count above the built maximum, widest alignment
        set_pool(4096, 511, 4096);
        write_reg(CFG_SPARE_IDX, 8191);
        add_random(120, 40, 1);

        // Zero block size and an empty pool that owns nothing
        set_pool(0, 0, 0);
        add_random(60, 40, 1);

        // Oversized block setting, count lowered to one with blocks still stacked
        set_pool(8191, 1, 8191);
        add_random(60, 40, 1);

        // Block 0 freed twice links to itself, so allocations never run out and
        // the used count climbs to saturation; no idling on either side
        set_pool(48, 256, 8);
        idle_pct = 0;
        add_req(OP_RESET, 0, 0, 0, 0);
        add_req(OP_FREE, 0, 0, 0, 0);
        add_req(OP_FREE, 0, 0, 0, 0);
        add_random(600, 97, 0);

        // Random mid-range configuration
        set_pool($urandom_range(4096, 1), $urandom_range(256, 1), 1 << $urandom_range(12));
        idle_pct = 12;
        add_random(100, 40, 1);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
